[hdl/sns_pkg.sv]
// Shared types and constants for the spring network time step block.
// Holds the item structs, the controller-to-datapath command and status structs,
// and the state and operation codes. No dependencies.
package sns_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int MAX_BONDS     = 512;
  localparam int PW            = $clog2(MAX_PARTICLES);
  localparam int BW            = $clog2(MAX_BONDS);
  localparam int NUM_CFG       = 6;
  localparam int CW            = 3;

  // Configuration register indexes.
  localparam logic [CW-1:0] CFG_STIFF   = 3'd0;
  localparam logic [CW-1:0] CFG_GRAV    = 3'd1;
  localparam logic [CW-1:0] CFG_DAMP    = 3'd2;
  localparam logic [CW-1:0] CFG_DT      = 3'd3;
  localparam logic [CW-1:0] CFG_CUTOFF  = 3'd4;
  localparam logic [CW-1:0] CFG_GSTIFF  = 3'd5;

  // Input modes.
  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_BOND = 2'd1;
  localparam logic [1:0] MODE_STEP = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_PFULL = 2'd1;
  localparam logic [1:0] STAT_BFULL = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         particle_id;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [47:0]        stress_level;
    logic [9:0]         bond_total;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_ADD, OP_PRD, OP_LAT_A, OP_LAT_B, OP_DIFF, OP_SQX, OP_SQY,
    OP_BRD, OP_BLAT, OP_BWR, OP_FORCE, OP_FSQ, OP_FDX, OP_TX, OP_FDY, OP_TY,
    OP_UPD_A, OP_UPD_B, OP_A_MX, OP_A_MY, OP_A_WR,
    OP_C_M1, OP_C_M2, OP_C_M3, OP_C_M4, OP_C_M5, OP_C_M6, OP_C_M7, OP_C_WR,
    OP_EMIT_PLAIN, OP_EMIT_REP
  } dp_op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_ADD, S_FULL, S_NONE,
    S_BI_RD, S_BI_LAT, S_BJ_RD, S_BJ_LAT, S_DIFF, S_SQX, S_SQY, S_B_CHK, S_B_WR, S_B_END,
    S_A_RD, S_A_MX, S_A_MY, S_A_WR,
    S_K_RD, S_K_LAT, S_K_CHK, S_K_RDA, S_K_LATA, S_K_RDB, S_K_LATB,
    S_K_F, S_K_FF, S_K_FDX, S_K_TX, S_K_FDY, S_K_TY, S_K_RDA2, S_K_UPA, S_K_RDB2, S_K_UPB,
    S_C_RD, S_C_M1, S_C_M2, S_C_M3, S_C_M4, S_C_M5, S_C_M6, S_C_M7, S_C_WR,
    S_D_RD, S_D_OUT
  } state_t;

  typedef struct packed {
    dp_op_t      op;
    logic [PW-1:0] paddr;
    logic [PW-1:0] pi;
    logic [PW-1:0] pj;
    logic [BW-1:0] bidx;
    logic [BW:0]   bcount;
    logic [1:0]    status;
    logic          last;
  } dp_cmd_t;

  typedef struct packed {
    logic          mul_done;
    logic          near;
    logic          py_neg;
    logic [PW-1:0] a;
    logic [PW-1:0] b;
  } dp_stat_t;

endpackage

[hdl/sns_ram.sv]
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module sns_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/sns_mul.sv]
// Digit-serial Q16.16 multiplier: 16-bit digit of a by 34-bit b per cycle.
// Gives the floored, saturated Q16.16 product and the raw product shifted by 16.
module sns_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [33:0] b,
  output logic               busy,
  output logic               done,
  output logic [31:0]        q,
  output logic [47:0]        sq
);

  logic [63:0] ma_r, ma_nxt;
  logic [33:0] mb_r, mb_nxt;
  logic [97:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [81:0] qm;

  always_comb begin
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      ma_nxt   = a[63] ? 64'(-a) : 64'(a);
      mb_nxt   = b[33] ? 34'(-b) : 34'(b);
      neg_nxt  = a[63] ^ b[33];
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Most significant digit first, so the accumulator shifts by a constant.
      acc_nxt = {acc_r[81:0], 16'b0} + 98'(ma_r[63:48] * mb_r);
      ma_nxt  = {ma_r[47:0], 16'b0};
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
  end

  // A negative product with a nonzero fraction rounds its magnitude up (floor).
  assign qm = acc_r[97:16] + 82'(neg_r && (acc_r[15:0] != 16'b0));

  always_comb begin
    if (!neg_r) begin
      q = (qm > 82'h7FFF_FFFF) ? 32'h7FFF_FFFF : qm[31:0];
    end else begin
      q = (qm > 82'h8000_0000) ? 32'h8000_0000 : 32'(-qm[31:0]);
    end
  end

  assign sq   = acc_r[63:16];
  assign busy = busy_r;
  assign done = done_r;

endmodule

[hdl/sns_dp.sv]
// Datapath: configuration registers, particle and bond memories, the shared
// multiplier and the working registers. Depends on sns_pkg, sns_ram and sns_mul.
module sns_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sns_pkg::dp_cmd_t          cmd,
  output sns_pkg::dp_stat_t         stat,
  input  sns_pkg::in_item_t         in_item,
  input  logic                      cfg_we,
  input  logic [sns_pkg::CW-1:0]    cfg_index,
  input  logic [31:0]               cfg_data,
  output logic                      out_strobe,
  output sns_pkg::out_item_t        out_item
);

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      return v[31:0];
    end else if (v[33]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  function automatic logic signed [33:0] sx34(input logic [31:0] v);
    return $signed({{2{v[31]}}, v});
  endfunction

  logic [31:0] stiff_r, grav_r, damp_r, dt_r, cutoff_r, gstiff_r;

  logic signed [31:0] inx_r, iny_r;
  logic [31:0] xi_r, yi_r, xj_r, yj_r;
  logic signed [32:0] dx_r, dy_r;
  logic [48:0] sq_r;
  logic [31:0] rest_r;
  logic [31:0] f_r, t_r, tx_r, ty_r;
  logic [47:0] f2_r;
  logic [sns_pkg::PW-1:0] a_r, b_r;
  logic        ostb_r;
  sns_pkg::out_item_t oitem_r, oitem_nxt;

  logic [31:0] px_q, py_q, vx_q, vy_q;
  logic [47:0] st_q;
  logic [5:0]  bf_q, bs_q;
  logic [31:0] br_q;

  logic p_re, pxy_we, vxy_we, st_we, b_re, b_we;
  logic [31:0] px_d, py_d, vx_d, vy_d;
  logic [47:0] st_d;

  logic               mul_op, mul_busy, mul_done;
  logic signed [63:0] mul_a;
  logic signed [33:0] mul_b;
  logic [31:0]        mul_q;
  logic [47:0]        mul_sq;
  logic signed [49:0] dlt;
  logic [48:0]        st_sum;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r  <= 32'd65536000;
      grav_r   <= 32'd6554;
      damp_r   <= 32'd6554;
      dt_r     <= 32'd655;
      cutoff_r <= 32'd203162;
      gstiff_r <= 32'd655360;
    end else if (cfg_we) begin
      case (cfg_index)
        sns_pkg::CFG_STIFF:  stiff_r  <= cfg_data;
        sns_pkg::CFG_GRAV:   grav_r   <= cfg_data;
        sns_pkg::CFG_DAMP:   damp_r   <= cfg_data;
        sns_pkg::CFG_DT:     dt_r     <= cfg_data;
        sns_pkg::CFG_CUTOFF: cutoff_r <= cfg_data;
        sns_pkg::CFG_GSTIFF: gstiff_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dlt = $signed({1'b0, sq_r}) - $signed({18'b0, rest_r});

  always_comb begin
    mul_op = cmd.op inside {sns_pkg::OP_SQX, sns_pkg::OP_SQY, sns_pkg::OP_FORCE,
                            sns_pkg::OP_FSQ, sns_pkg::OP_FDX, sns_pkg::OP_TX,
                            sns_pkg::OP_FDY, sns_pkg::OP_TY, sns_pkg::OP_A_MX,
                            sns_pkg::OP_A_MY, sns_pkg::OP_C_M1, sns_pkg::OP_C_M2,
                            sns_pkg::OP_C_M3, sns_pkg::OP_C_M4, sns_pkg::OP_C_M5,
                            sns_pkg::OP_C_M6, sns_pkg::OP_C_M7};
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      sns_pkg::OP_SQX:   begin mul_a = 64'(dx_r);              mul_b = 34'(dx_r); end
      sns_pkg::OP_SQY:   begin mul_a = 64'(dy_r);              mul_b = 34'(dy_r); end
      sns_pkg::OP_FORCE: begin mul_a = 64'(dlt);               mul_b = {2'b0, stiff_r}; end
      sns_pkg::OP_FSQ:   begin mul_a = 64'($signed(f_r));      mul_b = sx34(f_r); end
      sns_pkg::OP_FDX:   begin mul_a = 64'($signed(f_r));      mul_b = 34'(dx_r); end
      sns_pkg::OP_FDY:   begin mul_a = 64'($signed(f_r));      mul_b = 34'(dy_r); end
      sns_pkg::OP_TX,
      sns_pkg::OP_TY,
      sns_pkg::OP_C_M2,
      sns_pkg::OP_C_M4,
      sns_pkg::OP_C_M7:  begin mul_a = 64'($signed(t_r));      mul_b = {2'b0, dt_r}; end
      sns_pkg::OP_A_MX:  begin mul_a = 64'($signed(vx_q));     mul_b = {2'b0, dt_r}; end
      sns_pkg::OP_A_MY:  begin mul_a = 64'($signed(vy_q));     mul_b = {2'b0, dt_r}; end
      sns_pkg::OP_C_M1:  begin mul_a = 64'($signed(vx_q));     mul_b = {2'b0, damp_r}; end
      sns_pkg::OP_C_M3:  begin mul_a = 64'($signed(vy_q));     mul_b = {2'b0, damp_r}; end
      sns_pkg::OP_C_M5:  begin mul_a = {32'b0, grav_r};        mul_b = {2'b0, dt_r}; end
      sns_pkg::OP_C_M6:  begin mul_a = {32'b0, gstiff_r};      mul_b = sx34(py_q); end
      default: ;
    endcase
  end

  sns_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_op && !mul_busy && !mul_done),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .q     (mul_q),
    .sq    (mul_sq)
  );

  // Working registers; multiplier results are taken in the cycle that done is high.
  always_ff @(posedge clk) begin
    case (cmd.op)
      sns_pkg::OP_LOAD:  begin inx_r <= in_item.pos_x; iny_r <= in_item.pos_y; end
      sns_pkg::OP_LAT_A: begin xi_r <= px_q; yi_r <= py_q; end
      sns_pkg::OP_LAT_B: begin xj_r <= px_q; yj_r <= py_q; end
      sns_pkg::OP_DIFF: begin
        dx_r <= $signed({xj_r[31], xj_r}) - $signed({xi_r[31], xi_r});
        dy_r <= $signed({yj_r[31], yj_r}) - $signed({yi_r[31], yi_r});
      end
      sns_pkg::OP_BLAT: begin a_r <= bf_q; b_r <= bs_q; rest_r <= br_q; end
      default: ;
    endcase
    if (mul_done) begin
      case (cmd.op)
        sns_pkg::OP_SQX:   sq_r <= {1'b0, mul_sq};
        sns_pkg::OP_SQY:   sq_r <= sq_r + {1'b0, mul_sq};
        sns_pkg::OP_FORCE: f_r <= mul_q;
        sns_pkg::OP_FSQ:   f2_r <= mul_sq;
        sns_pkg::OP_FDX,
        sns_pkg::OP_FDY,
        sns_pkg::OP_C_M1,
        sns_pkg::OP_C_M3,
        sns_pkg::OP_C_M6:  t_r <= mul_q;
        sns_pkg::OP_TX,
        sns_pkg::OP_C_M4:  tx_r <= mul_q;
        sns_pkg::OP_TY:    ty_r <= mul_q;
        sns_pkg::OP_A_MX:  xi_r <= sat32(sx34(px_q) + sx34(mul_q));
        sns_pkg::OP_A_MY:  yi_r <= sat32(sx34(py_q) + sx34(mul_q));
        sns_pkg::OP_C_M2:  xi_r <= sat32(sx34(vx_q) - sx34(mul_q));
        sns_pkg::OP_C_M5:  yi_r <= sat32(sx34(vy_q) - sx34(tx_r) - sx34(mul_q));
        sns_pkg::OP_C_M7:  yi_r <= sat32(sx34(yi_r) - sx34(mul_q));
        default: ;
      endcase
    end
  end

  assign st_sum = {1'b0, st_q} + {1'b0, f2_r};

  always_comb begin
    p_re   = (cmd.op == sns_pkg::OP_PRD);
    b_re   = (cmd.op == sns_pkg::OP_BRD);
    b_we   = (cmd.op == sns_pkg::OP_BWR);
    pxy_we = 1'b0;
    vxy_we = 1'b0;
    st_we  = 1'b0;
    px_d   = xi_r;
    py_d   = yi_r;
    vx_d   = xi_r;
    vy_d   = yi_r;
    st_d   = st_sum[48] ? '1 : st_sum[47:0];
    case (cmd.op)
      sns_pkg::OP_ADD: begin
        pxy_we = 1'b1;
        vxy_we = 1'b1;
        px_d   = inx_r;
        py_d   = iny_r;
        vx_d   = '0;
        vy_d   = '0;
      end
      sns_pkg::OP_A_WR: begin
        pxy_we = 1'b1;
        st_we  = 1'b1;
        st_d   = '0;
      end
      sns_pkg::OP_UPD_A: begin
        vxy_we = 1'b1;
        st_we  = 1'b1;
        vx_d   = sat32(sx34(vx_q) + sx34(tx_r));
        vy_d   = sat32(sx34(vy_q) + sx34(ty_r));
      end
      sns_pkg::OP_UPD_B: begin
        vxy_we = 1'b1;
        st_we  = 1'b1;
        vx_d   = sat32(sx34(vx_q) - sx34(tx_r));
        vy_d   = sat32(sx34(vy_q) - sx34(ty_r));
      end
      sns_pkg::OP_C_WR: vxy_we = 1'b1;
      default: ;
    endcase
  end

  sns_ram #(.W(32), .D(sns_pkg::MAX_PARTICLES)) u_px (
    .clk(clk), .we(pxy_we), .waddr(cmd.paddr), .wdata(px_d),
    .re(p_re), .raddr(cmd.paddr), .rdata(px_q));
  sns_ram #(.W(32), .D(sns_pkg::MAX_PARTICLES)) u_py (
    .clk(clk), .we(pxy_we), .waddr(cmd.paddr), .wdata(py_d),
    .re(p_re), .raddr(cmd.paddr), .rdata(py_q));
  sns_ram #(.W(32), .D(sns_pkg::MAX_PARTICLES)) u_vx (
    .clk(clk), .we(vxy_we), .waddr(cmd.paddr), .wdata(vx_d),
    .re(p_re), .raddr(cmd.paddr), .rdata(vx_q));
  sns_ram #(.W(32), .D(sns_pkg::MAX_PARTICLES)) u_vy (
    .clk(clk), .we(vxy_we), .waddr(cmd.paddr), .wdata(vy_d),
    .re(p_re), .raddr(cmd.paddr), .rdata(vy_q));
  sns_ram #(.W(48), .D(sns_pkg::MAX_PARTICLES)) u_st (
    .clk(clk), .we(st_we), .waddr(cmd.paddr), .wdata(st_d),
    .re(p_re), .raddr(cmd.paddr), .rdata(st_q));
  sns_ram #(.W(6), .D(sns_pkg::MAX_BONDS)) u_bf (
    .clk(clk), .we(b_we), .waddr(cmd.bidx), .wdata(6'(cmd.pi)),
    .re(b_re), .raddr(cmd.bidx), .rdata(bf_q));
  sns_ram #(.W(6), .D(sns_pkg::MAX_BONDS)) u_bs (
    .clk(clk), .we(b_we), .waddr(cmd.bidx), .wdata(6'(cmd.pj)),
    .re(b_re), .raddr(cmd.bidx), .rdata(bs_q));
  sns_ram #(.W(32), .D(sns_pkg::MAX_BONDS)) u_br (
    .clk(clk), .we(b_we), .waddr(cmd.bidx), .wdata(sq_r[31:0]),
    .re(b_re), .raddr(cmd.bidx), .rdata(br_q));

  // Next result item.
  always_comb begin
    oitem_nxt.bond_total   = 10'(cmd.bcount);
    oitem_nxt.status       = cmd.status;
    oitem_nxt.last         = cmd.last;
    oitem_nxt.particle_id  = 6'(cmd.paddr);
    oitem_nxt.out_x        = '0;
    oitem_nxt.out_y        = '0;
    oitem_nxt.stress_level = '0;
    case (cmd.op)
      sns_pkg::OP_ADD: begin
        oitem_nxt.out_x = inx_r;
        oitem_nxt.out_y = iny_r;
      end
      sns_pkg::OP_EMIT_REP: begin
        oitem_nxt.out_x        = px_q;
        oitem_nxt.out_y        = py_q;
        oitem_nxt.stress_level = st_q;
      end
      sns_pkg::OP_EMIT_PLAIN: oitem_nxt.particle_id = '0;
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ostb_r <= 1'b0;
    end else begin
      ostb_r <= cmd.op inside {sns_pkg::OP_ADD, sns_pkg::OP_EMIT_PLAIN,
                               sns_pkg::OP_EMIT_REP};
    end
    oitem_r <= oitem_nxt;
  end

  assign out_strobe    = ostb_r;
  assign out_item      = oitem_r;
  assign stat.mul_done = mul_done;
  assign stat.near     = (sq_r <= {17'b0, cutoff_r});
  assign stat.py_neg   = py_q[31];
  assign stat.a        = a_r;
  assign stat.b        = b_r;

endmodule

[hdl/sns_ctrl.sv]
// Controller state machine: walks the particle and bond loops and issues one
// datapath command per cycle. Depends on sns_pkg.
module sns_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [1:0]         mode,
  input  sns_pkg::dp_stat_t  stat,
  output logic               busy,
  output sns_pkg::dp_cmd_t   cmd
);

  localparam logic [sns_pkg::PW:0] PMAX = (sns_pkg::PW+1)'(sns_pkg::MAX_PARTICLES);
  localparam logic [sns_pkg::BW:0] BMAX = (sns_pkg::BW+1)'(sns_pkg::MAX_BONDS);

  sns_pkg::state_t state_r, state_nxt;
  logic [sns_pkg::PW:0] pc_r, pc_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [sns_pkg::BW:0] bc_r, bc_nxt, k_r, k_nxt;
  logic [1:0] status_r, status_nxt;
  logic       bonding_r, bonding_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sns_pkg::S_IDLE;
      pc_r      <= '0;
      bc_r      <= '0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      status_r  <= sns_pkg::STAT_OK;
      bonding_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pc_r      <= pc_nxt;
      bc_r      <= bc_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      k_r       <= k_nxt;
      status_r  <= status_nxt;
      bonding_r <= bonding_nxt;
    end
  end

  // Next state and loop counters.
  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    bc_nxt      = bc_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    status_nxt  = status_r;
    bonding_nxt = bonding_r;
    case (state_r)
      sns_pkg::S_IDLE: begin
        if (accept) begin
          status_nxt = sns_pkg::STAT_OK;
          i_nxt      = '0;
          case (mode)
            sns_pkg::MODE_ADD:  state_nxt = (pc_r >= PMAX) ? sns_pkg::S_FULL : sns_pkg::S_ADD;
            sns_pkg::MODE_BOND: begin
              bonding_nxt = 1'b1;
              state_nxt   = (pc_r >= 2) ? sns_pkg::S_BI_RD : sns_pkg::S_B_END;
            end
            sns_pkg::MODE_STEP: begin
              bonding_nxt = 1'b0;
              state_nxt   = (pc_r == '0) ? sns_pkg::S_NONE : sns_pkg::S_A_RD;
            end
            default: ;
          endcase
        end
      end
      sns_pkg::S_ADD: begin
        pc_nxt    = pc_r + 1'b1;
        state_nxt = sns_pkg::S_IDLE;
      end
      sns_pkg::S_FULL,
      sns_pkg::S_NONE,
      sns_pkg::S_B_END: state_nxt = sns_pkg::S_IDLE;
      sns_pkg::S_BI_RD: state_nxt = sns_pkg::S_BI_LAT;
      sns_pkg::S_BI_LAT: begin
        j_nxt     = i_r + 1'b1;
        state_nxt = sns_pkg::S_BJ_RD;
      end
      sns_pkg::S_BJ_RD:  state_nxt = sns_pkg::S_BJ_LAT;
      sns_pkg::S_BJ_LAT: state_nxt = sns_pkg::S_DIFF;
      sns_pkg::S_DIFF:   state_nxt = sns_pkg::S_SQX;
      sns_pkg::S_SQX:    if (stat.mul_done) state_nxt = sns_pkg::S_SQY;
      sns_pkg::S_SQY: begin
        if (stat.mul_done) state_nxt = bonding_r ? sns_pkg::S_B_CHK : sns_pkg::S_K_F;
      end
      sns_pkg::S_B_CHK,
      sns_pkg::S_B_WR: begin
        if (state_r == sns_pkg::S_B_CHK && stat.near) begin
          if (bc_r >= BMAX) begin
            status_nxt = sns_pkg::STAT_BFULL;
            state_nxt  = sns_pkg::S_B_END;
          end else begin
            state_nxt = sns_pkg::S_B_WR;
          end
        end else begin
          if (state_r == sns_pkg::S_B_WR) bc_nxt = bc_r + 1'b1;
          if (j_r + 1'b1 < pc_r) begin
            j_nxt     = j_r + 1'b1;
            state_nxt = sns_pkg::S_BJ_RD;
          end else if (i_r + 2'd2 < pc_r) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = sns_pkg::S_BI_RD;
          end else begin
            state_nxt = sns_pkg::S_B_END;
          end
        end
      end
      sns_pkg::S_A_RD: state_nxt = sns_pkg::S_A_MX;
      sns_pkg::S_A_MX: if (stat.mul_done) state_nxt = sns_pkg::S_A_MY;
      sns_pkg::S_A_MY: if (stat.mul_done) state_nxt = sns_pkg::S_A_WR;
      sns_pkg::S_A_WR: begin
        if (i_r + 1'b1 < pc_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = sns_pkg::S_A_RD;
        end else begin
          i_nxt     = '0;
          k_nxt     = '0;
          state_nxt = (bc_r == '0) ? sns_pkg::S_C_RD : sns_pkg::S_K_RD;
        end
      end
      sns_pkg::S_K_RD:  state_nxt = sns_pkg::S_K_LAT;
      sns_pkg::S_K_LAT: state_nxt = sns_pkg::S_K_CHK;
      sns_pkg::S_K_CHK,
      sns_pkg::S_K_UPB: begin
        // A bond whose end lies outside the stored particles is skipped.
        if (state_r == sns_pkg::S_K_CHK && {1'b0, stat.a} < pc_r && {1'b0, stat.b} < pc_r) begin
          state_nxt = sns_pkg::S_K_RDA;
        end else if (k_r + 1'b1 < bc_r) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = sns_pkg::S_K_RD;
        end else begin
          i_nxt     = '0;
          state_nxt = sns_pkg::S_C_RD;
        end
      end
      sns_pkg::S_K_RDA:  state_nxt = sns_pkg::S_K_LATA;
      sns_pkg::S_K_LATA: state_nxt = sns_pkg::S_K_RDB;
      sns_pkg::S_K_RDB:  state_nxt = sns_pkg::S_K_LATB;
      sns_pkg::S_K_LATB: state_nxt = sns_pkg::S_DIFF;
      sns_pkg::S_K_F:    if (stat.mul_done) state_nxt = sns_pkg::S_K_FF;
      sns_pkg::S_K_FF:   if (stat.mul_done) state_nxt = sns_pkg::S_K_FDX;
      sns_pkg::S_K_FDX:  if (stat.mul_done) state_nxt = sns_pkg::S_K_TX;
      sns_pkg::S_K_TX:   if (stat.mul_done) state_nxt = sns_pkg::S_K_FDY;
      sns_pkg::S_K_FDY:  if (stat.mul_done) state_nxt = sns_pkg::S_K_TY;
      sns_pkg::S_K_TY:   if (stat.mul_done) state_nxt = sns_pkg::S_K_RDA2;
      sns_pkg::S_K_RDA2: state_nxt = sns_pkg::S_K_UPA;
      sns_pkg::S_K_UPA:  state_nxt = sns_pkg::S_K_RDB2;
      sns_pkg::S_K_RDB2: state_nxt = sns_pkg::S_K_UPB;
      sns_pkg::S_C_RD:   state_nxt = sns_pkg::S_C_M1;
      sns_pkg::S_C_M1:   if (stat.mul_done) state_nxt = sns_pkg::S_C_M2;
      sns_pkg::S_C_M2:   if (stat.mul_done) state_nxt = sns_pkg::S_C_M3;
      sns_pkg::S_C_M3:   if (stat.mul_done) state_nxt = sns_pkg::S_C_M4;
      sns_pkg::S_C_M4:   if (stat.mul_done) state_nxt = sns_pkg::S_C_M5;
      sns_pkg::S_C_M5: begin
        if (stat.mul_done) state_nxt = stat.py_neg ? sns_pkg::S_C_M6 : sns_pkg::S_C_WR;
      end
      sns_pkg::S_C_M6:   if (stat.mul_done) state_nxt = sns_pkg::S_C_M7;
      sns_pkg::S_C_M7:   if (stat.mul_done) state_nxt = sns_pkg::S_C_WR;
      sns_pkg::S_C_WR: begin
        if (i_r + 1'b1 < pc_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = sns_pkg::S_C_RD;
        end else begin
          i_nxt     = '0;
          state_nxt = sns_pkg::S_D_RD;
        end
      end
      sns_pkg::S_D_RD: state_nxt = sns_pkg::S_D_OUT;
      sns_pkg::S_D_OUT: begin
        if (i_r + 1'b1 < pc_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = sns_pkg::S_D_RD;
        end else begin
          state_nxt = sns_pkg::S_IDLE;
        end
      end
      default: state_nxt = sns_pkg::S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd.op     = sns_pkg::OP_NOP;
    cmd.paddr  = i_r[sns_pkg::PW-1:0];
    cmd.pi     = i_r[sns_pkg::PW-1:0];
    cmd.pj     = j_r[sns_pkg::PW-1:0];
    cmd.bidx   = k_r[sns_pkg::BW-1:0];
    cmd.bcount = bc_r;
    cmd.status = status_r;
    cmd.last   = 1'b1;
    case (state_r)
      sns_pkg::S_IDLE: if (accept) cmd.op = sns_pkg::OP_LOAD;
      sns_pkg::S_ADD: begin
        cmd.op     = sns_pkg::OP_ADD;
        cmd.paddr  = pc_r[sns_pkg::PW-1:0];
        cmd.status = sns_pkg::STAT_OK;
      end
      sns_pkg::S_FULL: begin
        cmd.op     = sns_pkg::OP_EMIT_PLAIN;
        cmd.status = sns_pkg::STAT_PFULL;
      end
      sns_pkg::S_NONE: begin
        cmd.op     = sns_pkg::OP_EMIT_PLAIN;
        cmd.status = sns_pkg::STAT_EMPTY;
      end
      sns_pkg::S_B_END:  cmd.op = sns_pkg::OP_EMIT_PLAIN;
      sns_pkg::S_BI_RD:  cmd.op = sns_pkg::OP_PRD;
      sns_pkg::S_BI_LAT: cmd.op = sns_pkg::OP_LAT_A;
      sns_pkg::S_BJ_RD: begin
        cmd.op    = sns_pkg::OP_PRD;
        cmd.paddr = j_r[sns_pkg::PW-1:0];
      end
      sns_pkg::S_BJ_LAT: cmd.op = sns_pkg::OP_LAT_B;
      sns_pkg::S_DIFF:   cmd.op = sns_pkg::OP_DIFF;
      sns_pkg::S_SQX:    cmd.op = sns_pkg::OP_SQX;
      sns_pkg::S_SQY:    cmd.op = sns_pkg::OP_SQY;
      sns_pkg::S_B_WR: begin
        cmd.op   = sns_pkg::OP_BWR;
        cmd.bidx = bc_r[sns_pkg::BW-1:0];
      end
      sns_pkg::S_A_RD:   cmd.op = sns_pkg::OP_PRD;
      sns_pkg::S_A_MX:   cmd.op = sns_pkg::OP_A_MX;
      sns_pkg::S_A_MY:   cmd.op = sns_pkg::OP_A_MY;
      sns_pkg::S_A_WR:   cmd.op = sns_pkg::OP_A_WR;
      sns_pkg::S_K_RD:   cmd.op = sns_pkg::OP_BRD;
      sns_pkg::S_K_LAT:  cmd.op = sns_pkg::OP_BLAT;
      sns_pkg::S_K_RDA,
      sns_pkg::S_K_RDA2: begin
        cmd.op    = sns_pkg::OP_PRD;
        cmd.paddr = stat.a;
      end
      sns_pkg::S_K_LATA: cmd.op = sns_pkg::OP_LAT_A;
      sns_pkg::S_K_RDB,
      sns_pkg::S_K_RDB2: begin
        cmd.op    = sns_pkg::OP_PRD;
        cmd.paddr = stat.b;
      end
      sns_pkg::S_K_LATB: cmd.op = sns_pkg::OP_LAT_B;
      sns_pkg::S_K_F:    cmd.op = sns_pkg::OP_FORCE;
      sns_pkg::S_K_FF:   cmd.op = sns_pkg::OP_FSQ;
      sns_pkg::S_K_FDX:  cmd.op = sns_pkg::OP_FDX;
      sns_pkg::S_K_TX:   cmd.op = sns_pkg::OP_TX;
      sns_pkg::S_K_FDY:  cmd.op = sns_pkg::OP_FDY;
      sns_pkg::S_K_TY:   cmd.op = sns_pkg::OP_TY;
      sns_pkg::S_K_UPA: begin
        cmd.op    = sns_pkg::OP_UPD_A;
        cmd.paddr = stat.a;
      end
      sns_pkg::S_K_UPB: begin
        cmd.op    = sns_pkg::OP_UPD_B;
        cmd.paddr = stat.b;
      end
      sns_pkg::S_C_RD:   cmd.op = sns_pkg::OP_PRD;
      sns_pkg::S_C_M1:   cmd.op = sns_pkg::OP_C_M1;
      sns_pkg::S_C_M2:   cmd.op = sns_pkg::OP_C_M2;
      sns_pkg::S_C_M3:   cmd.op = sns_pkg::OP_C_M3;
      sns_pkg::S_C_M4:   cmd.op = sns_pkg::OP_C_M4;
      sns_pkg::S_C_M5:   cmd.op = sns_pkg::OP_C_M5;
      sns_pkg::S_C_M6:   cmd.op = sns_pkg::OP_C_M6;
      sns_pkg::S_C_M7:   cmd.op = sns_pkg::OP_C_M7;
      sns_pkg::S_C_WR:   cmd.op = sns_pkg::OP_C_WR;
      sns_pkg::S_D_RD:   cmd.op = sns_pkg::OP_PRD;
      sns_pkg::S_D_OUT: begin
        cmd.op     = sns_pkg::OP_EMIT_REP;
        cmd.status = sns_pkg::STAT_OK;
        cmd.last   = (i_r + 1'b1 == pc_r);
      end
      default: ;
    endcase
  end

  assign busy = (state_r != sns_pkg::S_IDLE);

endmodule

[hdl/spring_network_time_step.sv]
// Top level of the two-dimensional mass-spring network stepper.
// Depends on sns_pkg, sns_ctrl and sns_dp (which holds sns_ram and sns_mul).
//
// Usage:
//   A command is transferred when start is high and busy is low; in_item carries
//   the mode and, for an add, the position. Results leave on out_item, each valid
//   for exactly one cycle while out_strobe is high; the receiver cannot stall them,
//   and last marks the final result of a command. Configuration registers are
//   written through cfg_valid/cfg_index/cfg_data (cfg_ready is always high) and
//   must only be written while busy is low and no result is still pending.
// Operation:
//   Every Q16.16 product goes through one digit-serial multiplier, and the
//   controller waits for each product. An add result appears in the cycle in
//   which busy drops. Bonding checks every particle pair and stores a bond
//   for each pair within the cutoff. A step moves all positions, applies the
//   force of each stored bond, then damping, gravity and ground for each
//   particle, and then reports each particle in turn.
// Reset:
//   rst_n clears the particle and bond counts and loads the default register
//   values. Memory contents are not cleared; only written entries are ever read.
module spring_network_time_step (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  sns_pkg::in_item_t      in_item,
  output logic                   out_strobe,
  output sns_pkg::out_item_t     out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [sns_pkg::CW-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  sns_pkg::dp_cmd_t  cmd;
  sns_pkg::dp_stat_t stat;
  logic              busy_w;

  assign cfg_ready = 1'b1;
  assign busy      = busy_w;

  sns_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (start && !busy_w),
    .mode   (in_item.mode),
    .stat   (stat),
    .busy   (busy_w),
    .cmd    (cmd)
  );

  sns_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_item    (in_item),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
